/* sv/wide_unsigned_alu64_top_assert.svh */
// Assertion macros for the wide unsigned ALU top level.
// Included by wide_unsigned_alu64_top; no other dependencies.
`ifndef WIDE_UNSIGNED_ALU64_TOP_ASSERT_SVH
`define WIDE_UNSIGNED_ALU64_TOP_ASSERT_SVH
// Implication checked at every clock edge outside reset.
`define WUA_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define WUA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

/* sv/wua_pkg.sv */
// Package for the wide unsigned ALU: widths, commands, status codes,
// the item carried between cells. No dependencies.
package wua_pkg;
    localparam int NumDivCells = 64;
    localparam int MaxShift = 32;

    typedef enum logic [2:0] {
        CMD_ADD = 3'd0, CMD_SUB = 3'd1, CMD_MUL = 3'd2,
        CMD_DIV = 3'd3, CMD_SHL = 3'd4
    } t_cmd;

    typedef enum logic [2:0] {
        ST_OK = 3'd0, ST_OVERFLOW = 3'd1, ST_NEGATIVE = 3'd2,
        ST_SHIFT_BIG = 3'd3, ST_ZERO_DIV = 3'd4
    } t_status;

    // Item handed from cell to cell: for divide, quo holds the dividend
    // bits not yet consumed (shifted left) and gathers quotient bits.
    typedef struct packed {
        logic        vld;
        logic        div;
        logic [63:0] quo;
        logic [16:0] rem;
        logic [15:0] dvs;
        logic [2:0]  status;
    } t_item;
endpackage

/* sv/wua_front.sv */
// Front stage: decodes the command, does add, subtract, shift and the
// multiply partial products; sets up divide. Uses wua_pkg.
module wua_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_vld,
    input  logic [2:0]      i_cmd,
    input  logic [63:0]     i_a,
    input  logic [63:0]     i_b,
    input  logic [31:0]     i_m,
    input  logic [15:0]     i_d,
    input  logic [5:0]      i_sh,
    output wua_pkg::t_item  o_item
);
    wua_pkg::t_item r_item, n_item;
    logic r_mul;
    logic [63:0] r_lo, r_hi;
    logic [64:0] w_sum;
    logic [64:0] w_p;

    // Multiply partial products are registered, then combined.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item.vld <= 1'b0;
            r_mul <= 1'b0;
        end else if (i_en) begin
            r_item.vld <= i_vld;
            r_mul <= i_vld && (i_cmd == wua_pkg::CMD_MUL);
        end
        if (i_en) begin
            r_item.div <= n_item.div;
            r_item.quo <= n_item.quo;
            r_item.rem <= n_item.rem;
            r_item.dvs <= n_item.dvs;
            r_item.status <= n_item.status;
            r_lo <= {32'd0, i_a[31:0]} * {32'd0, i_m};
            r_hi <= {32'd0, i_a[63:32]} * {32'd0, i_m};
        end
    end

    always_comb begin
        w_sum = {1'b0, i_a} + {1'b0, i_b};
        n_item = '0;
        n_item.vld = i_vld;
        case (i_cmd)
            wua_pkg::CMD_ADD: begin
                if (w_sum[64]) n_item.status = wua_pkg::ST_OVERFLOW;
                else n_item.quo = w_sum[63:0];
            end
            wua_pkg::CMD_SUB: begin
                if (i_a < i_b) begin
                    n_item.quo = i_a;
                    n_item.status = wua_pkg::ST_NEGATIVE;
                end else n_item.quo = i_a - i_b;
            end
            wua_pkg::CMD_DIV: begin
                if (i_d == 16'd0) n_item.status = wua_pkg::ST_ZERO_DIV;
                else begin
                    n_item.div = 1'b1;
                    n_item.quo = i_a;
                    n_item.dvs = i_d;
                end
            end
            wua_pkg::CMD_SHL: begin
                if (i_sh > 6'(wua_pkg::MaxShift)) n_item.status = wua_pkg::ST_SHIFT_BIG;
                else n_item.quo = i_a << i_sh;
            end
            default: n_item = n_item;
        endcase
    end

    // Combine multiply partials in the second half.
    always_comb begin
        w_p = {1'b0, r_lo} + {1'b0, r_hi[31:0], 32'd0};
        o_item = r_item;
        if (r_mul) begin
            o_item.quo = w_p[63:0];
            o_item.status = (r_hi[63:32] != 32'd0 || w_p[64])
                ? wua_pkg::ST_OVERFLOW : wua_pkg::ST_OK;
        end
    end
endmodule

/* sv/wua_div_cell.sv */
// One restoring-divide cell: consumes one dividend bit per item per cycle
// while i_en is high, and passes the item on. Uses wua_pkg.
module wua_div_cell (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  wua_pkg::t_item  i_item,
    output wua_pkg::t_item  o_item
);
    wua_pkg::t_item r_item, n_item;
    logic [16:0] w_trial;

    // Shift in next dividend bit, subtract divisor when it fits.
    always_comb begin
        n_item = i_item;
        w_trial = {i_item.rem[15:0], i_item.quo[63]};
        if (i_item.div) begin
            if (w_trial >= {1'b0, i_item.dvs}) begin
                n_item.rem = w_trial - {1'b0, i_item.dvs};
                n_item.quo = {i_item.quo[62:0], 1'b1};
            end else begin
                n_item.rem = w_trial;
                n_item.quo = {i_item.quo[62:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item.vld <= 1'b0;
        end else if (i_en) begin
            r_item.vld <= n_item.vld;
        end
        if (i_en) begin
            r_item.div <= n_item.div;
            r_item.quo <= n_item.quo;
            r_item.rem <= n_item.rem;
            r_item.dvs <= n_item.dvs;
            r_item.status <= n_item.status;
        end
    end

    assign o_item = r_item;
endmodule

/* sv/wide_unsigned_alu64_top.sv */
// Top level of the wide unsigned ALU: front stage, a chain of divide
// cells and an output skid buffer. Uses wua_pkg, wua_front, wua_div_cell.
//
// Usage: one command item enters on the s_axis channel, one result item
// leaves on m_axis, in order. s_axis tdata (low bit up): cmd[2:0],
// operand_a[63:0], operand_b[63:0], multiplier[31:0], divisor[15:0],
// shift_amount[5:0], zero fill. m_axis tdata: result_value[63:0],
// remainder_value[15:0], status[2:0], zero fill.
// Path: the front register takes the item at the accepting edge
// (multiply combine folded in), then the item passes the 64 divide cells
// and then the output register.
// Throughput: one item per cycle while the skid is empty; the whole chain
// advances as one pipeline, one divide cell per quotient bit sets the depth.
// Stall: the chain moves while the output skid stage has room; a held
// result keeps its data; the input accepts while the skid is empty.
// Reset: clears all valid bits, the pipeline is empty afterwards.
module wide_unsigned_alu64_top (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // cmd, operand_a, operand_b, multiplier, divisor, shift_amount, pad
    input  logic [191:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // result_value, remainder_value, status, pad
    output logic [87:0]  m_axis_tdata
);
    wua_pkg::t_item w_chain [0:wua_pkg::NumDivCells];
    wua_pkg::t_item w_last;
    logic w_en;
    logic r_ovld, r_svld;
    logic [82:0] r_odat, r_sdat, w_res;

    // Chain advances when the skid slot is empty.
    assign w_en = !r_svld;
    assign s_axis_tready = w_en;

    wua_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en),
        .i_vld(s_axis_tvalid),
        .i_cmd(s_axis_tdata[2:0]), .i_a(s_axis_tdata[66:3]),
        .i_b(s_axis_tdata[130:67]), .i_m(s_axis_tdata[162:131]),
        .i_d(s_axis_tdata[178:163]), .i_sh(s_axis_tdata[184:179]),
        .o_item(w_chain[0])
    );

    for (genvar g = 0; g < wua_pkg::NumDivCells; g++) begin : g_cell
        wua_div_cell u_cell (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en),
            .i_item(w_chain[g]), .o_item(w_chain[g+1])
        );
    end

    assign w_last = w_chain[wua_pkg::NumDivCells];
    assign w_res = {w_last.status, (w_last.div ? w_last.rem[15:0] : 16'd0),
                    w_last.quo};

    // Output register plus skid slot.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
            r_svld <= 1'b0;
        end else begin
            if (w_en) begin
                if (r_ovld && !m_axis_tready) begin
                    r_svld <= w_last.vld;
                end else begin
                    r_ovld <= w_last.vld;
                end
            end else if (m_axis_tready) begin
                r_svld <= 1'b0;
            end
        end
        if (w_en) begin
            if (r_ovld && !m_axis_tready) r_sdat <= w_res;
            else r_odat <= w_res;
        end else if (m_axis_tready) begin
            r_odat <= r_sdat;
        end
    end

    assign m_axis_tvalid = r_ovld;
    assign m_axis_tdata = {5'd0, r_odat};

    `include "wide_unsigned_alu64_top_assert.svh"
    `WUA_ASSERT_IMPL(a_skid_implies_out, i_clk, i_rst_n, r_svld, r_ovld)
    `WUA_ASSERT_NEXT(a_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata))
    `WUA_ASSERT_IMPL(a_status, i_clk, i_rst_n, m_axis_tvalid,
        m_axis_tdata[82:80] <= wua_pkg::ST_ZERO_DIV)
endmodule
